// File: hw/rtl/jac_pkg.sv
// package for the joystick axis conditioner
// holds payload structs, register indexes, controller states and command/status types
package jac_pkg;

    typedef struct packed {
        logic [3:0]         device_num;
        logic [3:0]         axis_num;
        logic signed [15:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] calibrated;
        logic signed [15:0] mapped;
        logic               mapped_valid;
        logic [4:0]         role_tag;
    } t_out_item;

    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] REG_SOURCE_DEVICE = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SOURCE_AXIS   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CALIBRATE     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_REVERSE       = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_DEADZONE      = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_OUTPUT_LOW    = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_OUTPUT_HIGH   = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_ROLE          = 3'd7;

    localparam int DivW = 33;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRACK,
        ST_NORM_SETUP,
        ST_NORM_DIV,
        ST_NORM_DONE,
        ST_DZ_SETUP,
        ST_DZ_DIV,
        ST_DZ_DONE,
        ST_SCALE_MUL,
        ST_SCALE_DONE,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic track;
        logic norm_setup;
        logic dz_setup;
        logic div_step;
        logic norm_done;
        logic dz_done;
        logic scale_mul;
        logic scale_done;
        logic publish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic match;
        logic div_last;
        logic norm_special;
        logic dz_zero;
    } t_dp_status;

endpackage

// File: hw/rtl/jac_ctrl.sv
// controller for the joystick axis conditioner
// sequences load, tracking, two divisions and output scaling; uses jac_pkg
module jac_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  jac_pkg::t_dp_status i_status,
    output jac_pkg::t_dp_cmd    o_cmd
);
    import jac_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_TRACK;
                end
            end
            ST_TRACK: begin
                if (i_status.match) begin
                    o_cmd.track = 1'b1;
                    n_state = ST_NORM_SETUP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_NORM_SETUP: begin
                o_cmd.norm_setup = 1'b1;
                n_state = i_status.norm_special ? ST_NORM_DONE : ST_NORM_DIV;
            end
            ST_NORM_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = ST_NORM_DONE;
            end
            ST_NORM_DONE: begin
                o_cmd.norm_done = 1'b1;
                n_state = ST_DZ_SETUP;
            end
            ST_DZ_SETUP: begin
                o_cmd.dz_setup = 1'b1;
                n_state = i_status.dz_zero ? ST_DZ_DONE : ST_DZ_DIV;
            end
            ST_DZ_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = ST_DZ_DONE;
            end
            ST_DZ_DONE: begin
                o_cmd.dz_done = 1'b1;
                n_state = ST_SCALE_MUL;
            end
            ST_SCALE_MUL: begin
                o_cmd.scale_mul = 1'b1;
                n_state = ST_SCALE_DONE;
            end
            ST_SCALE_DONE: begin
                o_cmd.scale_done = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // hand the result over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/jac_datapath.sv
// datapath for the joystick axis conditioner
// config registers, bounds, restoring divider, output multiplier; uses jac_pkg
module jac_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [jac_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [15:0]               i_cfg_data,
    input  jac_pkg::t_in_item         i_in_item,
    input  jac_pkg::t_dp_cmd          i_cmd,
    output jac_pkg::t_dp_status       o_status,
    output jac_pkg::t_out_item        o_out_item
);
    import jac_pkg::*;

    logic signed [4:0]  r_src_dev, r_src_axis;
    logic               r_calibrate, r_reverse;
    logic [14:0]        r_deadzone;
    logic signed [15:0] r_out_low, r_out_high;
    logic [4:0]         r_role;
    logic signed [15:0] r_bound_low, r_bound_high;

    t_in_item           r_item;
    logic signed [17:0] r_v;       // holds +-32768
    logic [DivW-1:0]    r_rem;
    logic [DivW-1:0]    r_quo;
    logic [DivW-1:0]    r_den;
    logic [5:0]         r_cnt;
    logic               r_neg;
    logic signed [34:0] r_prod;
    t_out_item          r_res;
    t_out_item          r_out;

    // config writes and bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_dev    <= -5'sd1;
            r_src_axis   <= -5'sd1;
            r_calibrate  <= 1'b0;
            r_reverse    <= 1'b0;
            r_deadzone   <= '0;
            r_out_low    <= -16'sd32768;
            r_out_high   <= 16'sd32767;
            r_role       <= '0;
            r_bound_low  <= -16'sd32768;
            r_bound_high <= 16'sd32767;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SOURCE_DEVICE: r_src_dev  <= i_cfg_data[4:0];
                    REG_SOURCE_AXIS:   r_src_axis <= i_cfg_data[4:0];
                    REG_CALIBRATE: begin
                        if (i_cfg_data[0] && !r_calibrate) begin
                            r_bound_low  <= 16'sd32767;
                            r_bound_high <= -16'sd32768;
                        end
                        r_calibrate <= i_cfg_data[0];
                    end
                    REG_REVERSE:     r_reverse  <= i_cfg_data[0];
                    REG_DEADZONE:    r_deadzone <= i_cfg_data[14:0];
                    REG_OUTPUT_LOW:  r_out_low  <= i_cfg_data;
                    REG_OUTPUT_HIGH: r_out_high <= i_cfg_data;
                    REG_ROLE:        r_role     <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.track && r_calibrate) begin
                if (r_item.sample > r_bound_high) r_bound_high <= r_item.sample;
                if (r_item.sample < r_bound_low)  r_bound_low  <= r_item.sample;
            end
        end
    end

    assign o_status.match = !r_src_dev[4] && !r_src_axis[4]
        && ({1'b0, r_item.device_num} == r_src_dev[4:0])
        && ({1'b0, r_item.axis_num} == r_src_axis[4:0]);

    // normalization operands
    logic signed [16:0] span, clamped, off;
    always_comb begin
        span = 17'(r_bound_high) - 17'(r_bound_low);
        clamped = 17'(r_item.sample);
        if (clamped > 17'(r_bound_high)) clamped = 17'(r_bound_high);
        if (clamped < 17'(r_bound_low))  clamped = 17'(r_bound_low);
        off = clamped - 17'(r_bound_low);
    end
    assign o_status.norm_special = (span <= 17'sd0);

    // deadzone operands
    logic [16:0] abs_v;
    logic [15:0] dz_den;
    assign abs_v  = r_v[17] ? 17'(-r_v) : 17'(r_v);
    assign dz_den = 16'd32768 - {1'b0, r_deadzone};
    assign o_status.dz_zero = (abs_v <= {2'b0, r_deadzone});

    // restoring divider step
    logic [DivW:0] trial;
    assign trial = {r_rem[DivW-1:0], r_quo[DivW-1]} - {1'b0, r_den};
    assign o_status.div_last = (r_cnt == 6'd1);

    logic signed [16:0] outdiff;
    logic signed [17:0] vp;
    logic signed [35:0] sum;
    logic signed [19:0] fin;
    assign outdiff = 17'(r_out_high) - 17'(r_out_low);
    assign vp      = r_v + 18'sd32768;
    assign sum     = 36'(r_prod) + 36'sd32768;
    assign fin     = 20'(r_out_low) + 20'(sum >>> 16);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_in_item;
        if (i_cmd.norm_setup) begin
            r_rem <= '0;
            r_cnt <= 6'd33;
            r_den <= DivW'(unsigned'(span));
            r_quo <= (DivW'(unsigned'(off)) << 16) + DivW'(unsigned'(span) >> 1);
            r_v   <= (span == 17'sd0) ? 18'sd0 : -18'sd32768;
        end
        if (i_cmd.dz_setup) begin
            r_rem <= '0;
            r_cnt <= 6'd33;
            r_den <= DivW'(dz_den);
            r_quo <= (DivW'(abs_v - {2'b0, r_deadzone}) << 15) + DivW'(dz_den >> 1);
            r_neg <= r_v[17];
            r_res.calibrated <= r_v > 18'sd32767 ? 16'sd32767 : r_v[15:0];
            if (o_status.dz_zero) r_v <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 6'd1;
            r_quo <= {r_quo[DivW-2:0], ~trial[DivW]};
            r_rem <= trial[DivW] ? {r_rem[DivW-2:0], r_quo[DivW-1]} : trial[DivW-1:0];
        end
        // reverse is applied right after normalization
        if (i_cmd.norm_done) begin
            // special cases already placed in r_v at setup
            if (o_status.norm_special) begin
                if (r_reverse) r_v <= -r_v;
            end else if (r_reverse) begin
                r_v <= 18'sd32768 - 18'(r_quo);
            end else begin
                r_v <= 18'(r_quo) - 18'sd32768;
            end
        end
        if (i_cmd.dz_done) begin
            if (!o_status.dz_zero)
                r_v <= r_neg ? -18'(r_quo) : 18'(r_quo);
        end
        if (i_cmd.scale_mul) r_prod <= vp * outdiff;
        if (i_cmd.scale_done) begin
            if (r_role != 5'd0 && !r_calibrate) begin
                r_res.mapped_valid <= 1'b1;
                r_res.role_tag     <= r_role;
                r_res.mapped <= fin > 20'sd32767 ? 16'sd32767 :
                                fin < -20'sd32768 ? -16'sd32768 : fin[15:0];
            end else begin
                r_res.mapped_valid <= 1'b0;
                r_res.role_tag     <= '0;
                r_res.mapped       <= '0;
            end
        end
        if (i_cmd.publish) r_out <= r_res;
    end

    assign o_out_item = r_out;

endmodule

// File: hw/rtl/joystick_axis_conditioner.sv
// joystick axis conditioner top level: controller plus datapath, uses jac_pkg
// each accepted sample runs through two 33-step divisions in the serial restoring divider;
// a new sample is accepted only after the current result has been published;
// a zero or inverted span or a value inside the deadzone skips a division
// samples from another source are dropped with no result
// synchronous active-low reset restores register defaults and full-scale bounds
module joystick_axis_conditioner (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  jac_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output jac_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [jac_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [15:0]               i_cfg_data
);
    import jac_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    jac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    jac_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_item  (o_out_item)
    );

endmodule
